// ----- src/sph2cart_pkg.sv -----
package sph2cart_pkg;

  localparam int DIST_BITS_DEF      = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  localparam int ELEV_W       = 8;
  localparam int AZ_W         = 9;
  localparam int DEG_W        = 9;
  localparam int IDX_W        = 7;
  localparam int SINE_ENTRIES = 91;

  localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
  localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

  // pi in Q4.60
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic                 neg;
    logic [IDX_W-1:0]     idx;
  } fold_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } coord_sign_t;

  // map 0..359 degrees onto a first-quadrant table index plus sign of sine
  function automatic fold_t fold_deg(input logic [DEG_W-1:0] d);
    fold_t f;
    f = '0;
    priority if (d <= DEG_90) begin
      f.neg = 1'b0;
      f.idx = IDX_W'(d);
    end else if (d <= DEG_180) begin
      f.neg = 1'b0;
      f.idx = IDX_W'(DEG_180 - d);
    end else if (d <= DEG_270) begin
      f.neg = 1'b1;
      f.idx = IDX_W'(d - DEG_180);
    end else begin
      f.neg = 1'b1;
      f.idx = IDX_W'(DEG_360 - d);
    end
    return f;
  endfunction

  // sin(k deg) rounded to nearest in Q1.frac; Taylor series in Q60, evaluated at elaboration
  function automatic logic [63:0] sine_entry(input int k, input int frac);
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] prod;
    int           n;
    int           sh;
    step = PI_Q60 / 64'd180;
    x    = step * 64'(k);
    prod = {64'd0, x} * {64'd0, x};
    x2   = prod[123:60];
    term = x;
    sum  = x;
    for (n = 1; n <= 24; n++) begin
      prod = {64'd0, term} * {64'd0, x2};
      term = prod[123:60] / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sh = 60 - frac;
    return (sum + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ----- src/sph2cart_trig.sv -----
module sph2cart_trig
  import sph2cart_pkg::*;
#(
  parameter int DIST_BITS      = DIST_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ELEV_W-1:0]         elevation_deg,
  input  logic [AZ_W-1:0]           azimuth_deg,
  input  logic [DIST_BITS-1:0]      distance,
  output logic [DIST_BITS-1:0]      dist_q,
  output logic [TRIG_FRAC_BITS:0]   sin_colat,
  output logic [TRIG_FRAC_BITS:0]   cos_colat,
  output logic [TRIG_FRAC_BITS:0]   sin_az,
  output logic [TRIG_FRAC_BITS:0]   cos_az,
  output coord_sign_t               sign_q
);

  localparam int SIN_W = TRIG_FRAC_BITS + 1;

  logic [SIN_W-1:0] sine_rom [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    assign sine_rom[k] = SIN_W'(sine_entry(k, TRIG_FRAC_BITS));
  end

  // stage 1: angle reduction and quadrant folding
  logic [DEG_W:0]   elev_ext;
  logic [DEG_W:0]   colat_raw;
  logic [DEG_W-1:0] colat;
  logic [DEG_W:0]   colat_shift;
  logic [DEG_W-1:0] colat_c;
  logic [DEG_W-1:0] az;
  logic [DEG_W:0]   az_shift;
  logic [DEG_W-1:0] az_c;

  always_comb begin
    elev_ext  = {{(DEG_W + 1 - ELEV_W){elevation_deg[ELEV_W-1]}}, elevation_deg};
    colat_raw = {1'b0, DEG_90} - elev_ext;
    // negative colatitude wraps into 0..359
    if (colat_raw[DEG_W]) begin
      colat = DEG_W'(colat_raw + {1'b0, DEG_360});
    end else begin
      colat = colat_raw[DEG_W-1:0];
    end
    colat_shift = {1'b0, colat} + {1'b0, DEG_90};
    if (colat_shift >= {1'b0, DEG_360}) begin
      colat_c = DEG_W'(colat_shift - {1'b0, DEG_360});
    end else begin
      colat_c = colat_shift[DEG_W-1:0];
    end
    if (azimuth_deg >= DEG_360) begin
      az = azimuth_deg - DEG_360;
    end else begin
      az = azimuth_deg;
    end
    az_shift = {1'b0, az} + {1'b0, DEG_90};
    if (az_shift >= {1'b0, DEG_360}) begin
      az_c = DEG_W'(az_shift - {1'b0, DEG_360});
    end else begin
      az_c = az_shift[DEG_W-1:0];
    end
  end

  fold_t                f_sa;
  fold_t                f_ca;
  fold_t                f_sb;
  fold_t                f_cb;
  logic [DIST_BITS-1:0] dist_s1;

  always_ff @(posedge clk) begin
    if (en) begin
      f_sa    <= fold_deg(colat);
      f_ca    <= fold_deg(colat_c);
      f_sb    <= fold_deg(az);
      f_cb    <= fold_deg(az_c);
      dist_s1 <= distance;
    end
  end

  // stage 2: table lookups
  always_ff @(posedge clk) begin
    if (en) begin
      dist_q       <= dist_s1;
      sin_colat    <= sine_rom[f_sa.idx];
      cos_colat    <= sine_rom[f_ca.idx];
      sin_az       <= sine_rom[f_sb.idx];
      cos_az       <= sine_rom[f_cb.idx];
      sign_q.x_neg <= f_sa.neg ^ f_cb.neg;
      sign_q.y_neg <= f_sa.neg ^ f_sb.neg;
      sign_q.z_neg <= f_ca.neg;
    end
  end

endmodule

// ----- src/sph2cart_mult.sv -----
module sph2cart_mult
  import sph2cart_pkg::*;
#(
  parameter int DIST_BITS      = DIST_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [DIST_BITS-1:0]                          radius,
  input  logic [TRIG_FRAC_BITS:0]                       sin_colat,
  input  logic [TRIG_FRAC_BITS:0]                       cos_colat,
  input  logic [TRIG_FRAC_BITS:0]                       sin_az,
  input  logic [TRIG_FRAC_BITS:0]                       cos_az,
  input  coord_sign_t                                   sign_in,
  output logic [(DIST_BITS+TRIG_FRAC_BITS+1)/2+TRIG_FRAC_BITS:0] x_lo,
  output logic [(DIST_BITS+TRIG_FRAC_BITS+1)-(DIST_BITS+TRIG_FRAC_BITS+1)/2+TRIG_FRAC_BITS:0]
                                                        x_hi,
  output logic [(DIST_BITS+TRIG_FRAC_BITS+1)/2+TRIG_FRAC_BITS:0] y_lo,
  output logic [(DIST_BITS+TRIG_FRAC_BITS+1)-(DIST_BITS+TRIG_FRAC_BITS+1)/2+TRIG_FRAC_BITS:0]
                                                        y_hi,
  output logic [DIST_BITS-1:0]                          z_mag,
  output coord_sign_t                                   sign_out
);

  localparam int SIN_W   = TRIG_FRAC_BITS + 1;
  localparam int RA_W    = DIST_BITS + SIN_W;
  localparam int RA_LO_W = RA_W / 2;
  localparam int RA_HI_W = RA_W - RA_LO_W;

  // stage 3: r * sin(colat) and r * cos(colat)
  logic [RA_W-1:0]  ra;
  logic [RA_W-1:0]  rz;
  logic [SIN_W-1:0] sb_s3;
  logic [SIN_W-1:0] cb_s3;
  coord_sign_t      sign_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      ra      <= RA_W'(radius) * RA_W'(sin_colat);
      rz      <= RA_W'(radius) * RA_W'(cos_colat);
      sb_s3   <= sin_az;
      cb_s3   <= cos_az;
      sign_s3 <= sign_in;
    end
  end

  // stage 4: ra split in halves so each multiply stays narrow
  always_ff @(posedge clk) begin
    if (en) begin
      x_lo     <= (RA_LO_W + SIN_W)'(ra[RA_LO_W-1:0]) * (RA_LO_W + SIN_W)'(cb_s3);
      x_hi     <= (RA_HI_W + SIN_W)'(ra[RA_W-1:RA_LO_W]) * (RA_HI_W + SIN_W)'(cb_s3);
      y_lo     <= (RA_LO_W + SIN_W)'(ra[RA_LO_W-1:0]) * (RA_LO_W + SIN_W)'(sb_s3);
      y_hi     <= (RA_HI_W + SIN_W)'(ra[RA_W-1:RA_LO_W]) * (RA_HI_W + SIN_W)'(sb_s3);
      z_mag    <= rz[TRIG_FRAC_BITS +: DIST_BITS];
      sign_out <= sign_s3;
    end
  end

endmodule

// ----- src/spherical_to_cartesian_core.sv -----
// Spherical-to-Cartesian converter: each item carries elevation (degrees, signed), azimuth
// (degrees) and distance r; the result is x = r*sin(colat)*cos(az), y = r*sin(colat)*sin(az),
// z = r*cos(colat) with colat = 90 - elevation, trig from a per-degree Q1.TRIG_FRAC_BITS
// sine table, magnitudes truncated toward zero. Out-of-range angles wrap modulo 360.
// The pipeline has five register stages (angle fold, table lookup, r*sin/cos, partial
// products, combine and sign), and one item is taken every cycle unless the output stalls.
// The output register drives a single advance signal: when the result is not taken, the
// whole pipeline holds and s_tready drops.
module spherical_to_cartesian_core
  import sph2cart_pkg::*;
#(
  parameter int DIST_BITS      = DIST_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // elevation_deg[7:0], azimuth_deg[16:8], distance[DIST_BITS+16:17], zero pad
  input  logic [((ELEV_W+AZ_W+DIST_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // pos_x, pos_y, pos_z, each DIST_BITS+1 bits, from bit 0 up, zero pad
  output logic [((3*(DIST_BITS+1)+7)/8)*8-1:0] m_tdata
);

  localparam int SIN_W     = TRIG_FRAC_BITS + 1;
  localparam int RA_W      = DIST_BITS + SIN_W;
  localparam int RA_LO_W   = RA_W / 2;
  localparam int RA_HI_W   = RA_W - RA_LO_W;
  localparam int PROD_W    = RA_W + SIN_W;
  localparam int POS_W     = DIST_BITS + 1;
  localparam int OUT_W     = 3 * POS_W;
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int STAGES    = 4;

  logic              adv;
  logic [STAGES-1:0] stage_valid;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      m_tvalid    <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[STAGES-2:0], s_tvalid};
      m_tvalid    <= stage_valid[STAGES-1];
    end
  end

  logic [DIST_BITS-1:0] dist_t;
  logic [SIN_W-1:0]     sin_colat;
  logic [SIN_W-1:0]     cos_colat;
  logic [SIN_W-1:0]     sin_az;
  logic [SIN_W-1:0]     cos_az;
  coord_sign_t          sign_t;

  sph2cart_trig #(
    .DIST_BITS      (DIST_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk           (clk),
    .en            (adv),
    .elevation_deg (s_tdata[ELEV_W-1:0]),
    .azimuth_deg   (s_tdata[ELEV_W +: AZ_W]),
    .distance      (s_tdata[ELEV_W+AZ_W +: DIST_BITS]),
    .dist_q        (dist_t),
    .sin_colat     (sin_colat),
    .cos_colat     (cos_colat),
    .sin_az        (sin_az),
    .cos_az        (cos_az),
    .sign_q        (sign_t)
  );

  logic [RA_LO_W+SIN_W-1:0] x_lo;
  logic [RA_HI_W+SIN_W-1:0] x_hi;
  logic [RA_LO_W+SIN_W-1:0] y_lo;
  logic [RA_HI_W+SIN_W-1:0] y_hi;
  logic [DIST_BITS-1:0]     z_mag;
  coord_sign_t              sign_m;

  sph2cart_mult #(
    .DIST_BITS      (DIST_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mult (
    .clk       (clk),
    .en        (adv),
    .radius    (dist_t),
    .sin_colat (sin_colat),
    .cos_colat (cos_colat),
    .sin_az    (sin_az),
    .cos_az    (cos_az),
    .sign_in   (sign_t),
    .x_lo      (x_lo),
    .x_hi      (x_hi),
    .y_lo      (y_lo),
    .y_hi      (y_hi),
    .z_mag     (z_mag),
    .sign_out  (sign_m)
  );

  // stage 5: recombine partial products, drop 2*frac bits, apply sign
  logic [PROD_W-1:0]    x_full;
  logic [PROD_W-1:0]    y_full;
  logic [POS_W-1:0]     x_ext;
  logic [POS_W-1:0]     y_ext;
  logic [POS_W-1:0]     z_ext;
  logic [POS_W-1:0]     pos_x_next;
  logic [POS_W-1:0]     pos_y_next;
  logic [POS_W-1:0]     pos_z_next;

  always_comb begin
    x_full     = (PROD_W'(x_hi) << RA_LO_W) + PROD_W'(x_lo);
    y_full     = (PROD_W'(y_hi) << RA_LO_W) + PROD_W'(y_lo);
    x_ext      = {1'b0, x_full[2*TRIG_FRAC_BITS +: DIST_BITS]};
    y_ext      = {1'b0, y_full[2*TRIG_FRAC_BITS +: DIST_BITS]};
    z_ext      = {1'b0, z_mag};
    pos_x_next = sign_m.x_neg ? (POS_W'(0) - x_ext) : x_ext;
    pos_y_next = sign_m.y_neg ? (POS_W'(0) - y_ext) : y_ext;
    pos_z_next = sign_m.z_neg ? (POS_W'(0) - z_ext) : z_ext;
  end

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  assign m_tdata = M_TDATA_W'({pos_z, pos_y, pos_x});

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stage_valid[0])
    else $error("accepted item did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(stage_valid))
    else $error("pipeline valids moved during stall");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    adv && stage_valid[STAGES-1] |=> m_tvalid)
    else $error("item in last stage did not reach output");

endmodule
